/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is active
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(label, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* rtl/svp_pkg.sv */
package svp_pkg;

  // width of the major, minor and patch values
  localparam int VALUE_WIDTH = 64;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  // character codes
  localparam logic [7:0] CH_V    = 8'h76;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_STAR = 8'h2a;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // input transaction
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_string;
  } in_t;

  // result transaction
  typedef struct packed {
    value_t major_value;
    value_t minor_value;
    value_t patch_value;
    logic   status;
  } out_t;

  // parse phase, one-hot
  typedef enum logic [6:0] {
    PH_START      = 7'b0000001,
    PH_AFTER_V    = 7'b0000010,
    PH_MAJOR      = 7'b0000100,
    PH_MINOR      = 7'b0001000,
    PH_MINOR_STAR = 7'b0010000,
    PH_PATCH      = 7'b0100000,
    PH_PATCH_STAR = 7'b1000000
  } phase_t;

  // control from the input stage to the parse core
  typedef struct packed {
    logic step;
    in_t  item;
  } step_t;

  // acc * 10 + digit as two shifts and two adds, wrapping at the value width
  function automatic value_t push_digit(value_t acc, logic [3:0] dig);
    return (acc << 3) + (acc << 1) + value_t'(dig);
  endfunction

endpackage

/* rtl/semantic_version_parser.sv */
// pipeline: an accepted transaction is registered in the input stage and parsed from there; an
//   end transaction's result is then registered in the result register and offered from it
// throughput: one character per cycle; only an end transaction waits, and only
//   while the result register is full and stalled
// reset: synchronous active-low rst_n clears both stage valids and returns the parser
//   to its start phase with all three values at all ones
module semantic_version_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  svp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output svp_pkg::out_t out_data
);

  logic          s1_valid_r;
  svp_pkg::in_t  s1_item_r;
  logic          out_valid_r;
  svp_pkg::out_t out_item_r;

  logic           out_free;
  logic           s1_go;
  svp_pkg::step_t ctl;
  svp_pkg::out_t  report;

  // the input stage moves on unless it holds an end transaction with no result room
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_item_r.end_of_string || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  assign ctl.step = s1_go;
  assign ctl.item = s1_item_r;

  svp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .report (report)
  );

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_go && s1_item_r.end_of_string) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (s1_go && s1_item_r.end_of_string) begin
      out_item_r <= report;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

/* rtl/svp_core.sv */
module svp_core (
  input  logic           clk,
  input  logic           rst_n,
  input  svp_pkg::step_t ctl,
  output svp_pkg::out_t  report
);

  svp_pkg::phase_t phase_r, phase_nxt;
  svp_pkg::value_t major_r, major_nxt;
  svp_pkg::value_t minor_r, minor_nxt;
  svp_pkg::value_t patch_r, patch_nxt;
  logic            err_r, err_nxt;

  logic [7:0] ch;
  logic [7:0] digit_ofs;
  logic [3:0] dig;
  logic       is_digit;
  logic       is_dot;
  logic       is_star;
  logic       bad;

  // character classes
  assign ch        = ctl.item.ch;
  assign digit_ofs = ch - svp_pkg::CH_ZERO;
  assign dig       = digit_ofs[3:0];
  assign is_digit  = (ch >= svp_pkg::CH_ZERO) && (ch <= svp_pkg::CH_NINE);
  assign is_dot    = (ch == svp_pkg::CH_DOT);
  assign is_star   = (ch == svp_pkg::CH_STAR);

  // result for an end transaction, taken from the current state
  assign bad = err_r || (phase_r == svp_pkg::PH_MINOR_STAR);
  always_comb begin
    if (bad) begin
      report.major_value = '1;
      report.minor_value = '1;
      report.patch_value = '1;
      report.status      = svp_pkg::STATUS_BAD;
    end else begin
      report.major_value = major_r;
      report.minor_value = minor_r;
      report.patch_value = patch_r;
      report.status      = svp_pkg::STATUS_OK;
    end
  end

  // next state for one character; an end transaction restarts the parse
  always_comb begin
    phase_nxt = phase_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    patch_nxt = patch_r;
    err_nxt   = err_r;
    if (ctl.step) begin
      if (ctl.item.end_of_string) begin
        phase_nxt = svp_pkg::PH_START;
        major_nxt = '1;
        minor_nxt = '1;
        patch_nxt = '1;
        err_nxt   = 1'b0;
      end else if (!err_r) begin
        unique case (phase_r)
          svp_pkg::PH_START, svp_pkg::PH_AFTER_V: begin
            if (phase_r == svp_pkg::PH_START && ch == svp_pkg::CH_V) begin
              phase_nxt = svp_pkg::PH_AFTER_V;
            end else if (is_digit) begin
              major_nxt = svp_pkg::value_t'(dig);
              phase_nxt = svp_pkg::PH_MAJOR;
            end else if (is_dot) begin
              major_nxt = '0;
              minor_nxt = '0;
              phase_nxt = svp_pkg::PH_MINOR;
            end else begin
              major_nxt = '0;
              phase_nxt = svp_pkg::PH_MAJOR;
              err_nxt   = 1'b1;
            end
          end
          svp_pkg::PH_MAJOR: begin
            if (is_digit) begin
              major_nxt = svp_pkg::push_digit(major_r, dig);
            end else if (is_dot) begin
              minor_nxt = '0;
              phase_nxt = svp_pkg::PH_MINOR;
            end else begin
              err_nxt = 1'b1;
            end
          end
          svp_pkg::PH_MINOR: begin
            if (is_star && minor_r == '0) begin
              minor_nxt = '1;
              phase_nxt = svp_pkg::PH_MINOR_STAR;
            end else if (is_digit) begin
              minor_nxt = svp_pkg::push_digit(minor_r, dig);
            end else if (is_dot) begin
              patch_nxt = '0;
              phase_nxt = svp_pkg::PH_PATCH;
            end else begin
              err_nxt = 1'b1;
            end
          end
          svp_pkg::PH_MINOR_STAR: begin
            if (is_dot) begin
              patch_nxt = '0;
              phase_nxt = svp_pkg::PH_PATCH;
            end else begin
              err_nxt = 1'b1;
            end
          end
          svp_pkg::PH_PATCH: begin
            if (is_star && patch_r == '0) begin
              patch_nxt = '1;
              phase_nxt = svp_pkg::PH_PATCH_STAR;
            end else if (is_digit) begin
              patch_nxt = svp_pkg::push_digit(patch_r, dig);
            end else begin
              err_nxt = 1'b1;
            end
          end
          default: begin
            err_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= svp_pkg::PH_START;
      major_r <= '1;
      minor_r <= '1;
      patch_r <= '1;
      err_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      patch_r <= patch_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* rtl/svp_checker.sv */
`include "assert_macros.svh"

module svp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input svp_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input svp_pkg::out_t out_data
);

  logic err_ones;
  logic out_wait;
  logic out_bad;
  logic in_wait;

  assign err_ones = (out_data.major_value == '1) && (out_data.minor_value == '1) &&
                    (out_data.patch_value == '1);
  assign out_wait = out_valid && out_stall;
  assign out_bad  = out_valid && (out_data.status == svp_pkg::STATUS_BAD);
  assign in_wait  = in_valid && in_stall;

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(out_data), "result changed")

  // a bad-format result carries all-ones values
  `ASSERT_IMPLIES(a_bad_ones, clk, rst_n, out_bad, err_ones, "bad result with values")

  // input backpressure only comes from a full, stalled result register
  `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_wait, "input stalled without cause")

  // a stalled input transaction holds
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, in_valid && $stable(in_data), "input changed")

endmodule

bind semantic_version_parser svp_checker u_svp_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam svp_pkg::value_t ONES = '1;
  localparam svp_pkg::out_t NO_WANT = '0;
  localparam svp_pkg::out_t BLANK_OK = '{ONES, ONES, ONES, svp_pkg::STATUS_OK};
  localparam svp_pkg::out_t REJECTED = '{ONES, ONES, ONES, svp_pkg::STATUS_BAD};
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 135;

  typedef struct {
    svp_pkg::in_t  item;
    bit            typed;
    svp_pkg::out_t want;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  svp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  svp_pkg::out_t out_data;

  // parser shadow state
  svp_pkg::phase_t cur_phase;
  svp_pkg::value_t maj_sum;
  svp_pkg::value_t min_sum;
  svp_pkg::value_t pat_sum;
  bit              bad_seen;

  svp_pkg::out_t pending_versions[$];
  svp_pkg::in_t  str_q[$];
  dir_row_t      dir_rows[$];

  int send_idle_pct;
  int recv_stall_pct;
  int n_items;
  int n_strings;
  int n_results;
  int n_rejected;
  int n_errors;
  int quiet_cycles;

  semantic_version_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #10 clk = ~clk;

  // back to the start phase, all values unset
  function automatic void clear_parse();
    cur_phase = svp_pkg::PH_START;
    maj_sum = ONES;
    min_sum = ONES;
    pat_sum = ONES;
    bad_seen = 1'b0;
  endfunction

  function automatic svp_pkg::value_t shift_in_digit(svp_pkg::value_t acc, logic [7:0] c);
    return acc * svp_pkg::value_t'(10) + svp_pkg::value_t'(c - svp_pkg::CH_ZERO);
  endfunction

  function automatic void take_major(logic [7:0] c, bit digit);
    if (digit) begin
      maj_sum = shift_in_digit(maj_sum, c);
    end else if (c == svp_pkg::CH_DOT) begin
      min_sum = '0;
      cur_phase = svp_pkg::PH_MINOR;
    end else begin
      bad_seen = 1'b1;
    end
  endfunction

  // advance the shadow parser by one transaction, returns 1 when a result is due
  function automatic bit parse_char(input svp_pkg::in_t it, output svp_pkg::out_t res);
    bit digit;
    digit = (it.ch >= svp_pkg::CH_ZERO) && (it.ch <= svp_pkg::CH_NINE);
    res = NO_WANT;
    if (it.end_of_string) begin
      if (bad_seen || cur_phase == svp_pkg::PH_MINOR_STAR) res = REJECTED;
      else res = '{maj_sum, min_sum, pat_sum, svp_pkg::STATUS_OK};
      clear_parse();
      return 1'b1;
    end
    if (bad_seen) return 1'b0;
    case (cur_phase)
      svp_pkg::PH_START, svp_pkg::PH_AFTER_V: begin
        if (cur_phase == svp_pkg::PH_START && it.ch == svp_pkg::CH_V) begin
          cur_phase = svp_pkg::PH_AFTER_V;
        end else begin
          maj_sum = '0;
          cur_phase = svp_pkg::PH_MAJOR;
          take_major(it.ch, digit);
        end
      end
      svp_pkg::PH_MAJOR: take_major(it.ch, digit);
      svp_pkg::PH_MINOR: begin
        if (it.ch == svp_pkg::CH_STAR && min_sum == '0) begin
          min_sum = ONES;
          cur_phase = svp_pkg::PH_MINOR_STAR;
        end else if (digit) begin
          min_sum = shift_in_digit(min_sum, it.ch);
        end else if (it.ch == svp_pkg::CH_DOT) begin
          pat_sum = '0;
          cur_phase = svp_pkg::PH_PATCH;
        end else begin
          bad_seen = 1'b1;
        end
      end
      svp_pkg::PH_MINOR_STAR: begin
        if (it.ch == svp_pkg::CH_DOT) begin
          pat_sum = '0;
          cur_phase = svp_pkg::PH_PATCH;
        end else begin
          bad_seen = 1'b1;
        end
      end
      svp_pkg::PH_PATCH: begin
        if (it.ch == svp_pkg::CH_STAR && pat_sum == '0) begin
          pat_sum = ONES;
          cur_phase = svp_pkg::PH_PATCH_STAR;
        end else if (digit) begin
          pat_sum = shift_in_digit(pat_sum, it.ch);
        end else begin
          bad_seen = 1'b1;
        end
      end
      default: bad_seen = 1'b1;
    endcase
    return 1'b0;
  endfunction

  // drive one transaction and wait until it is taken
  task automatic send_item(input svp_pkg::in_t it, input bit typed, input svp_pkg::out_t want);
    svp_pkg::out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    if (parse_char(it, res)) begin
      n_strings++;
      pending_versions.push_back(typed ? want : res);
    end
  endtask

  function automatic void add_row(logic [7:0] c, bit eos, bit typed, svp_pkg::out_t want);
    dir_row_t row;
    row.item = '{ch: c, end_of_string: eos};
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_char(logic [7:0] c);
    str_q.push_back('{ch: c, end_of_string: 1'b0});
  endfunction

  function automatic void add_digits(int n);
    repeat (n) add_char(svp_pkg::CH_ZERO + 8'($urandom_range(9)));
  endfunction

  // mostly short numbers, now and then long enough to wrap
  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(15, 25);
  endfunction

  // minor or patch: digits, or a wildcard with an optional prefix
  function automatic void fill_field();
    if ($urandom_range(99) < 20) begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 2))
          add_char($urandom_range(1) ? svp_pkg::CH_ZERO :
                   svp_pkg::CH_ZERO + 8'($urandom_range(9)));
      end
      add_char(svp_pkg::CH_STAR);
    end else begin
      add_digits(pick_len());
    end
  endfunction

  // one version string, mostly well formed, sometimes noise or damaged
  task automatic send_random_string();
    int at;
    logic [7:0] odd;
    str_q.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(6)) add_char(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(1)) add_char(svp_pkg::CH_V);
      add_digits(pick_len());
      if ($urandom_range(99) >= 12) begin
        add_char(svp_pkg::CH_DOT);
        fill_field();
        if ($urandom_range(99) >= 12) begin
          add_char(svp_pkg::CH_DOT);
          fill_field();
        end
      end
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0: odd = svp_pkg::CH_DOT;
          1: odd = svp_pkg::CH_STAR;
          2: odd = svp_pkg::CH_V;
          default: odd = 8'($urandom_range(255));
        endcase
        at = $urandom_range(str_q.size());
        if (at == str_q.size()) add_char(odd);
        else str_q[at].ch = odd;
      end
    end
    foreach (str_q[k]) send_item(str_q[k], 1'b0, NO_WANT);
    send_item('{ch: 8'($urandom_range(255)), end_of_string: 1'b1}, 1'b0, NO_WANT);
  endtask

  // result channel backpressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // compare each result transaction with the oldest expected version
  always @(posedge clk) begin : check_results
    svp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_versions.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        n_errors++;
      end else begin
        want = pending_versions.pop_front();
        n_results++;
        if (want.status == svp_pkg::STATUS_BAD) n_rejected++;
        if (out_data.major_value !== want.major_value) begin
          $display("%0t: major expected %0d got %0d", $time, want.major_value,
                   out_data.major_value);
          n_errors++;
        end
        if (out_data.minor_value !== want.minor_value) begin
          $display("%0t: minor expected %0d got %0d", $time, want.minor_value,
                   out_data.minor_value);
          n_errors++;
        end
        if (out_data.patch_value !== want.patch_value) begin
          $display("%0t: patch expected %0d got %0d", $time, want.patch_value,
                   out_data.patch_value);
          n_errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0b got %0b", $time, want.status,
                   out_data.status);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int goal;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    quiet_cycles = 0;
    n_items = 0;
    n_strings = 0;
    n_results = 0;
    n_rejected = 0;
    n_errors = 0;
    send_idle_pct = 13;
    recv_stall_pct = 55;
    clear_parse();

    // empty string, lone v
    add_row(8'h00, 1'b1, 1'b1, BLANK_OK);
    add_row(svp_pkg::CH_V, 1'b0, 1'b0, NO_WANT);
    add_row(8'hff, 1'b1, 1'b1, BLANK_OK);
    // both wildcards
    add_row("9", 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_DOT, 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_STAR, 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_DOT, 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_STAR, 1'b0, 1'b0, NO_WANT);
    add_row(8'h00, 1'b1, 1'b0, NO_WANT);
    // bad first character
    add_row(8'hff, 1'b0, 1'b0, NO_WANT);
    add_row(8'hff, 1'b1, 1'b1, REJECTED);
    // minor wildcard closed by the end mark
    add_row("1", 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_DOT, 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_STAR, 1'b0, 1'b0, NO_WANT);
    add_row(8'h00, 1'b1, 1'b1, REJECTED);
    // leading dot, then wildcard after a nonzero minor
    add_row(svp_pkg::CH_DOT, 1'b0, 1'b0, NO_WANT);
    add_row("5", 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_STAR, 1'b0, 1'b0, NO_WANT);
    add_row(8'h00, 1'b1, 1'b1, REJECTED);
    // plain version
    add_row("1", 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_DOT, 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_ZERO, 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_DOT, 1'b0, 1'b0, NO_WANT);
    add_row(svp_pkg::CH_NINE, 1'b0, 1'b0, NO_WANT);
    add_row(8'h5a, 1'b1, 1'b0, NO_WANT);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // sender idles lightly, receiver heavily
    goal = n_items + ITEMS_PER_PHASE;
    while (n_items < goal) send_random_string();

    // hold off until every result has drained
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_versions.size() != 0);

    // swapped idling
    send_idle_pct = 55;
    recv_stall_pct = 13;
    goal = n_items + ITEMS_PER_PHASE;
    while (n_items < goal) send_random_string();

    // full rate
    send_idle_pct = 0;
    recv_stall_pct = 0;
    goal = n_items + ITEMS_PER_PHASE;
    while (n_items < goal) send_random_string();

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_versions.size() != 0);
    repeat (8) @(posedge clk);

    $display("sent %0d transactions in %0d strings under three idling mixes",
             n_items, n_strings);
    $display("checked %0d results, %0d of them rejected as invalid format",
             n_results, n_rejected);
    if (n_errors == 0 && pending_versions.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/svp_pkg.sv
rtl/svp_core.sv
rtl/semantic_version_parser.sv
rtl/svp_checker.sv
tb/tb.sv
